// ----- sv/mlfq_pkg.sv -----
// Shared constants, types and helper functions of the MLFQ task scheduler.
package mlfq_pkg;

  // Geometry
  localparam int MaxTasks    = 64;
  localparam int TaskW       = 6;
  localparam int UpperLevels = 2;
  localparam int BottomPris  = 4;
  localparam int NumQueues   = UpperLevels + BottomPris;
  localparam int QueueW      = 3;
  localparam int CountW      = 7;

  // Field widths
  localparam int ReqW     = 3;
  localparam int LevelW   = 2;
  localparam int PriW     = 2;
  localparam int QuantW   = 5;
  localparam int StatusW  = 2;
  localparam int BaseW    = 4;
  localparam int StepW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;
  localparam int ReloadW  = 6;
  localparam int QuantMax = 15;

  // Configuration reset values
  localparam logic [BaseW-1:0] BaseReset = 4'd4;
  localparam logic [StepW-1:0] StepReset = 3'd2;
  localparam logic [PriW-1:0]  BPriReset = 2'd3;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH          = 3'd0,
    REQ_PUSH_FRONT    = 3'd1,
    REQ_PUSH_FRONT_L0 = 3'd2,
    REQ_POP           = 3'd3,
    REQ_REMOVE        = 3'd4,
    REQ_BOOST         = 3'd5
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FAIL   = 2'd1,
    ST_QUEUED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_QUANTUM   = 2'd0,
    CFG_QUANTUM_STEP   = 2'd1,
    CFG_BOOST_PRIORITY = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SPLICE = 4'b0100,
    S_EXEC   = 4'b1000
  } state_e;

  // Per-task attributes kept in memory
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [PriW-1:0]   prio;
    logic [QuantW-1:0] quantum;
    logic [QueueW-1:0] queue;
  } attr_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;
    logic              rd;
    logic              mark;
    logic              splice;
    logic [QueueW-1:0] splice_idx;
    logic              exec;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_boost;
  } sts_t;

  function automatic logic [PriW-1:0] clamp_pri(input logic [PriW-1:0] p);
    clamp_pri = (int'(p) >= BottomPris) ? PriW'(BottomPris - 1) : p;
  endfunction

  // Order in which boost splices queues behind level 0
  function automatic logic [QueueW-1:0] splice_queue(input logic [QueueW-1:0] i);
    int q;
    q = (int'(i) < UpperLevels) ? int'(i) : (NumQueues - 1) - (int'(i) - UpperLevels);
    splice_queue = QueueW'(q);
  endfunction

endpackage

// ----- sv/mlfq_ctrl.sv -----
// Controller state machine of the MLFQ task scheduler.
module mlfq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mlfq_pkg::sts_t    sts_i,
  output mlfq_pkg::cmd_t    cmd_o
);

  mlfq_pkg::state_e                state_q, state_d;
  logic [mlfq_pkg::QueueW-1:0]     idx_q, idx_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  // result register can take a new beat
  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.splice_idx = idx_q;
    case (state_q)
      mlfq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mlfq_pkg::S_READ;
        end
      end
      mlfq_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
        if (sts_i.is_boost) begin
          cmd_o.mark = 1'b1;
          idx_d      = mlfq_pkg::QueueW'(1);
          state_d    = mlfq_pkg::S_SPLICE;
        end else begin
          state_d = mlfq_pkg::S_EXEC;
        end
      end
      mlfq_pkg::S_SPLICE: begin
        cmd_o.splice = 1'b1;
        if (idx_q == mlfq_pkg::QueueW'(mlfq_pkg::NumQueues - 1)) begin
          state_d = mlfq_pkg::S_EXEC;
        end else begin
          idx_d = idx_q + mlfq_pkg::QueueW'(1);
        end
      end
      mlfq_pkg::S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = mlfq_pkg::S_IDLE;
        end
      end
      default: state_d = mlfq_pkg::S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlfq_pkg::S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != mlfq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/mlfq_dp.sv -----
// Datapath of the MLFQ task scheduler: queues, link and attribute memories, result register.
module mlfq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mlfq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mlfq_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic [mlfq_pkg::ReqW-1:0]       req_type_i,
  input  logic [mlfq_pkg::TaskW-1:0]      task_id_i,
  input  logic [mlfq_pkg::LevelW-1:0]     task_level_i,
  input  logic [mlfq_pkg::PriW-1:0]       task_priority_i,
  input  logic signed [mlfq_pkg::QuantW-1:0] quantum_left_i,
  input  mlfq_pkg::cmd_t                  cmd_i,
  output mlfq_pkg::sts_t                  sts_o,
  output logic [mlfq_pkg::StatusW-1:0]    status_o,
  output logic [mlfq_pkg::TaskW-1:0]      out_task_o,
  output logic [mlfq_pkg::LevelW-1:0]     out_level_o,
  output logic [mlfq_pkg::PriW-1:0]       out_priority_o,
  output logic signed [mlfq_pkg::QuantW-1:0] out_quantum_o
);

  localparam int TW = mlfq_pkg::TaskW;
  localparam int QW = mlfq_pkg::QueueW;
  localparam int CW = mlfq_pkg::CountW;
  localparam int NQ = mlfq_pkg::NumQueues;
  localparam int NT = mlfq_pkg::MaxTasks;

  // configuration
  logic [mlfq_pkg::BaseW-1:0] base_q;
  logic [mlfq_pkg::StepW-1:0] step_q;
  logic [mlfq_pkg::PriW-1:0]  bpri_q;

  // values handed out by the last boost
  logic [mlfq_pkg::PriW-1:0]   boost_pri_q;
  logic [mlfq_pkg::QuantW-1:0] boost_qnt_q;

  // captured request
  logic [mlfq_pkg::ReqW-1:0]   req_q;
  logic [TW-1:0]               tid_q;
  logic [mlfq_pkg::LevelW-1:0] lvl_q;
  logic [mlfq_pkg::PriW-1:0]   pri_q;
  logic [mlfq_pkg::QuantW-1:0] qnt_q;

  // queue descriptors and per-task flags
  logic [TW-1:0] head_q [NQ];
  logic [TW-1:0] head_d [NQ];
  logic [TW-1:0] tail_q [NQ];
  logic [TW-1:0] tail_d [NQ];
  logic [CW-1:0] count_q [NQ];
  logic [CW-1:0] count_d [NQ];
  logic [NT-1:0] inq_q, inq_d;
  logic [NT-1:0] stale_q, stale_d;

  // memories and their read registers
  logic [TW-1:0]   next_mem [NT];
  logic [TW-1:0]   prev_mem [NT];
  mlfq_pkg::attr_t attr_mem [NT];
  logic [TW-1:0]   nxt_rd_q, prv_rd_q;
  mlfq_pkg::attr_t attr_rd_q;

  // memory write ports
  logic            nx_we, pv_we, at_we;
  logic [TW-1:0]   nx_addr, nx_data, pv_addr, pv_data;
  mlfq_pkg::attr_t at_data;

  // result register
  mlfq_pkg::status_e           res_status, out_status_q;
  logic [TW-1:0]               res_task, out_task_q;
  logic [mlfq_pkg::LevelW-1:0] res_level, out_level_q;
  logic [mlfq_pkg::PriW-1:0]   res_prio, out_prio_q;
  logic [mlfq_pkg::QuantW-1:0] res_qnt, out_qnt_q;

  logic                        pop_found;
  logic [QW-1:0]               pop_q, ul_q, sq, q_own, q_push;
  logic [TW-1:0]               rd_addr;
  logic                        task_inq, task_stale, rm_ok, do_unlink;
  mlfq_pkg::attr_t             eff;
  logic [mlfq_pkg::LevelW-1:0] lv_c, lv_n;
  logic [mlfq_pkg::PriW-1:0]   pr_c, pr_n;
  logic [mlfq_pkg::QuantW-1:0] qt_n;
  logic [mlfq_pkg::ReloadW-1:0] reload;
  logic                        demote;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= mlfq_pkg::BaseReset;
      step_q <= mlfq_pkg::StepReset;
      bpri_q <= mlfq_pkg::BPriReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlfq_pkg::CFG_BASE_QUANTUM:   base_q <= cfg_wdata_i[mlfq_pkg::BaseW-1:0];
        mlfq_pkg::CFG_QUANTUM_STEP:   step_q <= cfg_wdata_i[mlfq_pkg::StepW-1:0];
        mlfq_pkg::CFG_BOOST_PRIORITY: bpri_q <= cfg_wdata_i[mlfq_pkg::PriW-1:0];
        default: ;
      endcase
    end
  end

  // request capture and boost values
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      tid_q <= task_id_i;
      lvl_q <= task_level_i;
      pri_q <= task_priority_i;
      qnt_q <= quantum_left_i;
    end
    if (cmd_i.mark) begin
      boost_pri_q <= mlfq_pkg::clamp_pri(bpri_q);
      boost_qnt_q <= mlfq_pkg::QuantW'(base_q);
    end
  end

  assign sts_o.is_boost = (req_q == mlfq_pkg::REQ_BOOST);

  // first non-empty queue in service order
  always_comb begin
    pop_found = 1'b0;
    pop_q     = '0;
    for (int i = NQ - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        pop_found = 1'b1;
        pop_q     = QW'(i);
      end
    end
  end

  assign rd_addr    = (req_q == mlfq_pkg::REQ_POP) ? head_q[pop_q] : tid_q;
  assign task_inq   = inq_q[rd_addr];
  assign task_stale = stale_q[rd_addr];

  // attributes as seen after any boost
  always_comb begin
    eff = attr_rd_q;
    if (task_stale) begin
      eff.level   = '0;
      eff.prio    = boost_pri_q;
      eff.quantum = boost_qnt_q;
      eff.queue   = '0;
    end
  end

  // push attributes with demotion and quantum reload
  always_comb begin
    lv_c = (lvl_q > mlfq_pkg::LevelW'(mlfq_pkg::UpperLevels)) ?
           mlfq_pkg::LevelW'(mlfq_pkg::UpperLevels) : lvl_q;
    pr_c = mlfq_pkg::clamp_pri(pri_q);
    demote = (req_q == mlfq_pkg::REQ_PUSH) && (qnt_q[mlfq_pkg::QuantW-1] || qnt_q == '0);
    lv_n = lv_c;
    pr_n = pr_c;
    if (demote) begin
      if (int'(lv_c) < mlfq_pkg::UpperLevels) begin
        lv_n = lv_c + mlfq_pkg::LevelW'(1);
      end else if (pr_c != '0) begin
        pr_n = pr_c - mlfq_pkg::PriW'(1);
      end
    end
    reload = mlfq_pkg::ReloadW'(base_q) +
             mlfq_pkg::ReloadW'(step_q) * mlfq_pkg::ReloadW'(lv_n);
    if (!demote) begin
      qt_n = qnt_q;
    end else if (int'(reload) > mlfq_pkg::QuantMax) begin
      qt_n = mlfq_pkg::QuantW'(mlfq_pkg::QuantMax);
    end else begin
      qt_n = reload[mlfq_pkg::QuantW-1:0];
    end
    q_own  = (int'(lv_n) < mlfq_pkg::UpperLevels) ? QW'(lv_n) :
             QW'(mlfq_pkg::UpperLevels) + QW'(pr_n);
    q_push = (req_q == mlfq_pkg::REQ_PUSH_FRONT_L0) ? '0 : q_own;
  end

  // remove only a bottom-level task waiting in its own priority queue
  assign rm_ok = task_inq && (int'(eff.level) == mlfq_pkg::UpperLevels) &&
                 (eff.queue == QW'(mlfq_pkg::UpperLevels) + QW'(eff.prio));

  // queue update and result
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    inq_d   = inq_q;
    stale_d = stale_q;
    nx_we   = 1'b0;
    nx_addr = rd_addr;
    nx_data = rd_addr;
    pv_we   = 1'b0;
    pv_addr = rd_addr;
    pv_data = rd_addr;
    at_we   = 1'b0;
    at_data.level   = lv_n;
    at_data.prio    = pr_n;
    at_data.quantum = qt_n;
    at_data.queue   = q_push;
    res_status = mlfq_pkg::ST_FAIL;
    res_task   = '0;
    res_level  = '0;
    res_prio   = '0;
    res_qnt    = '0;
    do_unlink  = 1'b0;
    sq   = mlfq_pkg::splice_queue(cmd_i.splice_idx);
    ul_q = (req_q == mlfq_pkg::REQ_POP) ? pop_q : eff.queue;

    // boost: every queued task takes the boost attributes
    if (cmd_i.mark) begin
      stale_d = stale_q | inq_q;
    end

    // boost: hang one whole queue behind level 0
    if (cmd_i.splice && count_q[sq] != '0) begin
      if (count_q[0] == '0) begin
        head_d[0] = head_q[sq];
      end else begin
        nx_we   = 1'b1;
        nx_addr = tail_q[0];
        nx_data = head_q[sq];
        pv_we   = 1'b1;
        pv_addr = head_q[sq];
        pv_data = tail_q[0];
      end
      tail_d[0]   = tail_q[sq];
      count_d[0]  = count_q[0] + count_q[sq];
      count_d[sq] = '0;
    end

    case (req_q)
      mlfq_pkg::REQ_PUSH, mlfq_pkg::REQ_PUSH_FRONT, mlfq_pkg::REQ_PUSH_FRONT_L0: begin
        res_task = tid_q;
        if (task_inq) begin
          res_status = mlfq_pkg::ST_QUEUED;
          res_level  = eff.level;
          res_prio   = eff.prio;
          res_qnt    = eff.quantum;
        end else begin
          res_status = mlfq_pkg::ST_OK;
          res_level  = lv_n;
          res_prio   = pr_n;
          res_qnt    = qt_n;
          if (cmd_i.exec) begin
            at_we          = 1'b1;
            inq_d[tid_q]   = 1'b1;
            stale_d[tid_q] = 1'b0;
            if (req_q == mlfq_pkg::REQ_PUSH) begin
              if (count_q[q_push] == '0) begin
                head_d[q_push] = tid_q;
              end else begin
                nx_we   = 1'b1;
                nx_addr = tail_q[q_push];
                nx_data = tid_q;
                pv_we   = 1'b1;
                pv_addr = tid_q;
                pv_data = tail_q[q_push];
              end
              tail_d[q_push] = tid_q;
            end else begin
              if (count_q[q_push] == '0) begin
                tail_d[q_push] = tid_q;
              end else begin
                pv_we   = 1'b1;
                pv_addr = head_q[q_push];
                pv_data = tid_q;
                nx_we   = 1'b1;
                nx_addr = tid_q;
                nx_data = head_q[q_push];
              end
              head_d[q_push] = tid_q;
            end
            count_d[q_push] = count_q[q_push] + CW'(1);
          end
        end
      end
      mlfq_pkg::REQ_POP: begin
        if (pop_found) begin
          res_status = mlfq_pkg::ST_OK;
          res_task   = rd_addr;
          res_level  = eff.level;
          res_prio   = eff.prio;
          res_qnt    = eff.quantum;
          do_unlink  = cmd_i.exec;
        end
      end
      mlfq_pkg::REQ_REMOVE: begin
        res_task = tid_q;
        if (rm_ok) begin
          res_status = mlfq_pkg::ST_OK;
          res_level  = eff.level;
          res_prio   = eff.prio;
          res_qnt    = eff.quantum;
          do_unlink  = cmd_i.exec;
        end
      end
      mlfq_pkg::REQ_BOOST: begin
        res_status = mlfq_pkg::ST_OK;
        res_prio   = boost_pri_q;
        res_qnt    = boost_qnt_q;
      end
      default: ;
    endcase

    // take a task out of its queue
    if (do_unlink) begin
      if (head_q[ul_q] == rd_addr) begin
        head_d[ul_q] = nxt_rd_q;
      end else begin
        nx_we   = 1'b1;
        nx_addr = prv_rd_q;
        nx_data = nxt_rd_q;
      end
      if (tail_q[ul_q] == rd_addr) begin
        tail_d[ul_q] = prv_rd_q;
      end else begin
        pv_we   = 1'b1;
        pv_addr = nxt_rd_q;
        pv_data = prv_rd_q;
      end
      count_d[ul_q]  = count_q[ul_q] - CW'(1);
      inq_d[rd_addr] = 1'b0;
    end
  end

  // queue descriptors and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NQ; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
      inq_q   <= '0;
      stale_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      inq_q   <= inq_d;
      stale_q <= stale_d;
    end
  end

  // link and attribute memories
  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_addr] <= nx_data;
    if (pv_we) prev_mem[pv_addr] <= pv_data;
    if (at_we) attr_mem[tid_q] <= at_data;
    if (cmd_i.rd) begin
      nxt_rd_q  <= next_mem[rd_addr];
      prv_rd_q  <= prev_mem[rd_addr];
      attr_rd_q <= attr_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_task_q   <= res_task;
      out_level_q  <= res_level;
      out_prio_q   <= res_prio;
      out_qnt_q    <= res_qnt;
    end
  end

  assign status_o       = out_status_q;
  assign out_task_o     = out_task_q;
  assign out_level_o    = out_level_q;
  assign out_priority_o = out_prio_q;
  assign out_quantum_o  = $signed(out_qnt_q);

endmodule

// ----- sv/mlfq_task_scheduler_unit.sv -----
// Top level of the MLFQ task scheduler: controller, datapath and checks.
// For push, push-front, pop and remove the request beat is captured, the link
// and attribute memories are read at the task (or queue head) in the next cycle,
// and then, once the result register is free, links and queues are updated and
// the result register is loaded; a new request beat is taken the cycle after that,
// even while the result still waits. Boost splices five queues behind level 0,
// one queue at a time, between the memory read and the update.
// Link and attribute memories need no clearing after reset.
module mlfq_task_scheduler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mlfq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mlfq_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mlfq_pkg::ReqW-1:0]          req_type_i,
  input  logic [mlfq_pkg::TaskW-1:0]         task_id_i,
  input  logic [mlfq_pkg::LevelW-1:0]        task_level_i,
  input  logic [mlfq_pkg::PriW-1:0]          task_priority_i,
  input  logic signed [mlfq_pkg::QuantW-1:0] quantum_left_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mlfq_pkg::StatusW-1:0]       status_o,
  output logic [mlfq_pkg::TaskW-1:0]         out_task_o,
  output logic [mlfq_pkg::LevelW-1:0]        out_level_o,
  output logic [mlfq_pkg::PriW-1:0]          out_priority_o,
  output logic signed [mlfq_pkg::QuantW-1:0] out_quantum_o
);

  mlfq_pkg::cmd_t cmd;
  mlfq_pkg::sts_t sts;

  mlfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mlfq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .task_id_i       (task_id_i),
    .task_level_i    (task_level_i),
    .task_priority_i (task_priority_i),
    .quantum_left_i  (quantum_left_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .out_task_o      (out_task_o),
    .out_level_o     (out_level_o),
    .out_priority_o  (out_priority_o),
    .out_quantum_o   (out_quantum_o)
  );

  // an accepted beat keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while block not busy afterwards");

  // a result is only loaded when the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // delivered status is always a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mlfq_pkg::ST_OK || status_o == mlfq_pkg::ST_FAIL ||
                     status_o == mlfq_pkg::ST_QUEUED))
    else $error("undefined status code on result");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the MLFQ task scheduler with a built-in queue predictor.
`timescale 1ns / 100ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mlfq_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mlfq_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [mlfq_pkg::ReqW-1:0] req_type_i = '0;
  logic [mlfq_pkg::TaskW-1:0] task_id_i = '0;
  logic [mlfq_pkg::LevelW-1:0] task_level_i = '0;
  logic [mlfq_pkg::PriW-1:0] task_priority_i = '0;
  logic signed [mlfq_pkg::QuantW-1:0] quantum_left_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [mlfq_pkg::StatusW-1:0] status_o;
  logic [mlfq_pkg::TaskW-1:0] out_task_o;
  logic [mlfq_pkg::LevelW-1:0] out_level_o;
  logic [mlfq_pkg::PriW-1:0] out_priority_o;
  logic signed [mlfq_pkg::QuantW-1:0] out_quantum_o;

  mlfq_task_scheduler_unit i_dut (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [mlfq_pkg::StatusW-1:0] status;
    logic [mlfq_pkg::TaskW-1:0] task_id;
    logic [mlfq_pkg::LevelW-1:0] level;
    logic [mlfq_pkg::PriW-1:0] prio;
    logic signed [mlfq_pkg::QuantW-1:0] quantum;
  } sched_res_t;

  // Predictor state
  logic [mlfq_pkg::BaseW-1:0] m_base = mlfq_pkg::BaseReset;
  logic [mlfq_pkg::StepW-1:0] m_step = mlfq_pkg::StepReset;
  logic [mlfq_pkg::PriW-1:0] m_bpri = mlfq_pkg::BPriReset;
  int run_q[mlfq_pkg::NumQueues][$];
  bit m_queued[mlfq_pkg::MaxTasks];
  int m_qnum[mlfq_pkg::MaxTasks];
  logic [mlfq_pkg::LevelW-1:0] m_lvl[mlfq_pkg::MaxTasks];
  logic [mlfq_pkg::PriW-1:0] m_pri[mlfq_pkg::MaxTasks];
  logic signed [mlfq_pkg::QuantW-1:0] m_qnt[mlfq_pkg::MaxTasks];

  sched_res_t expected_res[$];
  int errors = 0;
  int idle_cycles = 0;
  int push_bias = 60;
  int rx_wait = 0;

  function automatic logic [mlfq_pkg::PriW-1:0] pri_lim(logic [mlfq_pkg::PriW-1:0] p);
    return (int'(p) >= mlfq_pkg::BottomPris) ? mlfq_pkg::PriW'(mlfq_pkg::BottomPris - 1) : p;
  endfunction

  function automatic sched_res_t task_res(logic [mlfq_pkg::StatusW-1:0] st, int t);
    return '{st, mlfq_pkg::TaskW'(t), m_lvl[t], m_pri[t], m_qnt[t]};
  endfunction

  // Computes the result of one request and updates the predictor queues
  function automatic sched_res_t predict_sched(logic [mlfq_pkg::ReqW-1:0] rq, int t,
      logic [mlfq_pkg::LevelW-1:0] lv_in, logic [mlfq_pkg::PriW-1:0] pr_in,
      logic signed [mlfq_pkg::QuantW-1:0] qn);
    int lv, pr, q, reload;
    lv = (lv_in > mlfq_pkg::UpperLevels) ? mlfq_pkg::UpperLevels : int'(lv_in);
    pr = pri_lim(pr_in);
    if (rq == mlfq_pkg::REQ_PUSH || rq == mlfq_pkg::REQ_PUSH_FRONT ||
        rq == mlfq_pkg::REQ_PUSH_FRONT_L0) begin
      if (m_queued[t]) return task_res(mlfq_pkg::ST_QUEUED, t);
      if (rq == mlfq_pkg::REQ_PUSH && qn <= 0) begin
        if (lv < mlfq_pkg::UpperLevels) lv++;
        else if (pr > 0) pr--;
        reload = m_base + m_step * lv;
        qn = (reload > mlfq_pkg::QuantMax) ? mlfq_pkg::QuantW'(mlfq_pkg::QuantMax) :
             mlfq_pkg::QuantW'(reload);
      end
      q = (lv < mlfq_pkg::UpperLevels) ? lv : mlfq_pkg::UpperLevels + pr;
      m_lvl[t] = mlfq_pkg::LevelW'(lv); m_pri[t] = mlfq_pkg::PriW'(pr); m_qnt[t] = qn;
      if (rq == mlfq_pkg::REQ_PUSH_FRONT_L0) q = 0;
      if (rq == mlfq_pkg::REQ_PUSH) run_q[q].push_back(t);
      else run_q[q].push_front(t);
      m_queued[t] = 1; m_qnum[t] = q;
      return task_res(mlfq_pkg::ST_OK, t);
    end
    if (rq == mlfq_pkg::REQ_POP) begin
      for (int i = 0; i < mlfq_pkg::NumQueues; i++)
        if (run_q[i].size() != 0) begin
          t = run_q[i].pop_front();
          m_queued[t] = 0;
          return task_res(mlfq_pkg::ST_OK, t);
        end
      return '{mlfq_pkg::ST_FAIL, '0, '0, '0, '0};
    end
    if (rq == mlfq_pkg::REQ_REMOVE) begin
      if (!m_queued[t] || m_lvl[t] < mlfq_pkg::UpperLevels ||
          m_qnum[t] != mlfq_pkg::UpperLevels + int'(m_pri[t]))
        return '{mlfq_pkg::ST_FAIL, mlfq_pkg::TaskW'(t), '0, '0, '0};
      q = m_qnum[t];
      foreach (run_q[q][k]) if (run_q[q][k] == t) begin run_q[q].delete(k); break; end
      m_queued[t] = 0;
      return task_res(mlfq_pkg::ST_OK, t);
    end
    if (rq == mlfq_pkg::REQ_BOOST) begin
      for (int i = 0; i < mlfq_pkg::MaxTasks; i++)
        if (m_queued[i]) begin
          m_lvl[i] = '0; m_pri[i] = pri_lim(m_bpri);
          m_qnt[i] = mlfq_pkg::QuantW'(m_base); m_qnum[i] = 0;
        end
      for (int i = 1; i < mlfq_pkg::NumQueues; i++) begin
        q = (i < mlfq_pkg::UpperLevels) ? i :
            (mlfq_pkg::NumQueues - 1) - (i - mlfq_pkg::UpperLevels);
        while (run_q[q].size() != 0) run_q[0].push_back(run_q[q].pop_front());
      end
      return '{mlfq_pkg::ST_OK, '0, '0, pri_lim(m_bpri), mlfq_pkg::QuantW'(m_base)};
    end
    return '{mlfq_pkg::ST_FAIL, '0, '0, '0, '0};
  endfunction

  // Sends one request beat after a random gap
  task automatic send_req(logic [mlfq_pkg::ReqW-1:0] rq, int t, int lv, int pr, int qn);
    int gap;
    logic [mlfq_pkg::TaskW-1:0] tid;
    logic [mlfq_pkg::LevelW-1:0] lvl;
    logic [mlfq_pkg::PriW-1:0] pri;
    logic signed [mlfq_pkg::QuantW-1:0] qnt;
    tid = mlfq_pkg::TaskW'(t);
    lvl = mlfq_pkg::LevelW'(lv);
    pri = mlfq_pkg::PriW'(pr);
    qnt = mlfq_pkg::QuantW'(qn);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq; task_id_i <= tid; task_level_i <= lvl;
    task_priority_i <= pri; quantum_left_i <= qnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_res.push_back(predict_sched(rq, int'(tid), lvl, pri, qnt));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(mlfq_pkg::cfg_e idx, int val);
    wait_drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= mlfq_pkg::CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mlfq_pkg::CFG_BASE_QUANTUM: m_base = mlfq_pkg::BaseW'(val);
      mlfq_pkg::CFG_QUANTUM_STEP: m_step = mlfq_pkg::StepW'(val);
      default: m_bpri = mlfq_pkg::PriW'(val);
    endcase
  endtask

  // Result checker; the receiver waits a random number of cycles per beat
  always @(posedge clk_i) begin
    sched_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result beat"); errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status_o); errors++; end
        if (out_task_o !== exp_r.task_id) begin
          $error("out_task exp %0d got %0d", exp_r.task_id, out_task_o); errors++; end
        if (out_level_o !== exp_r.level) begin
          $error("out_level exp %0d got %0d", exp_r.level, out_level_o); errors++; end
        if (out_priority_o !== exp_r.prio) begin
          $error("out_priority exp %0d got %0d", exp_r.prio, out_priority_o); errors++; end
        if (out_quantum_o !== exp_r.quantum) begin
          $error("out_quantum exp %0d got %0d", exp_r.quantum, out_quantum_o); errors++; end
      end
      rx_wait = $urandom_range(0, 10);
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait != 0);
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("** mlfq_task_scheduler_unit: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_req(mlfq_pkg::REQ_POP, 0, 0, 0, 0);
    send_req(mlfq_pkg::REQ_PUSH, 63, 0, 0, 15);
    send_req(mlfq_pkg::REQ_PUSH, 63, 0, 0, 1);
    send_req(mlfq_pkg::REQ_PUSH, 1, 3, 3, -8);
    send_req(mlfq_pkg::REQ_PUSH, 2, 2, 0, 0);
    send_req(mlfq_pkg::REQ_PUSH, 3, 1, 2, -1);
    send_req(mlfq_pkg::REQ_PUSH_FRONT, 4, 2, 2, 7);
    send_req(mlfq_pkg::REQ_PUSH_FRONT_L0, 5, 2, 1, 3);
    send_req(mlfq_pkg::REQ_REMOVE, 5, 0, 0, 0);
    send_req(mlfq_pkg::REQ_REMOVE, 4, 0, 0, 0);
    send_req(mlfq_pkg::REQ_REMOVE, 40, 0, 0, 0);
    send_req(mlfq_pkg::REQ_REMOVE, 63, 0, 0, 0);
    send_req(mlfq_pkg::REQ_BOOST, 0, 0, 0, 0);
    send_req(3'd6, 7, 1, 1, 1);
    send_req(3'd7, 0, 3, 3, -1);
    repeat (8) send_req(mlfq_pkg::REQ_POP, 0, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    write_cfg(mlfq_pkg::CFG_BASE_QUANTUM, 15);
    write_cfg(mlfq_pkg::CFG_QUANTUM_STEP, 7);
    write_cfg(mlfq_pkg::CFG_BOOST_PRIORITY, 0);
    send_req(mlfq_pkg::REQ_PUSH, 9, 1, 0, -3);
    send_req(mlfq_pkg::REQ_PUSH, 10, 2, 0, 0);
    send_req(mlfq_pkg::REQ_BOOST, 0, 0, 0, 0);
    send_req(mlfq_pkg::REQ_POP, 0, 0, 0, 0);
    send_req(mlfq_pkg::REQ_POP, 0, 0, 0, 0);
    write_cfg(mlfq_pkg::CFG_BASE_QUANTUM, 1);
    write_cfg(mlfq_pkg::CFG_QUANTUM_STEP, 0);
  endtask

  // Push-biased mix with a small id pool so that duplicates and removes hit
  task automatic test_random(int n);
    int r, rq;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_bias) rq = $urandom_range(0, 2);
      else if (r < 82) rq = mlfq_pkg::REQ_POP;
      else if (r < 94) rq = mlfq_pkg::REQ_REMOVE;
      else if (r < 98) rq = mlfq_pkg::REQ_BOOST;
      else rq = $urandom_range(6, 7);
      send_req(mlfq_pkg::ReqW'(rq),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15),
               $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 31));
      if (i == n / 2) wait_drain();
    end
  endtask

  task automatic test_config_sweep();
    for (int s = 0; s < 4; s++) begin
      write_cfg(mlfq_pkg::CFG_BASE_QUANTUM, $urandom_range(1, 15));
      write_cfg(mlfq_pkg::CFG_QUANTUM_STEP, $urandom_range(0, 7));
      write_cfg(mlfq_pkg::CFG_BOOST_PRIORITY, s);
      push_bias = (s % 2) ? 45 : 70;
      test_random(300);
    end
  endtask

  initial begin
    foreach (m_queued[i]) m_queued[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random(100);
    test_config_sweep();
    wait_drain();
    if (errors == 0) $display("** mlfq_task_scheduler_unit: PASSED **");
    else $display("** mlfq_task_scheduler_unit: FAILED **");
    $finish;
  end

endmodule
